### hdl/stt_pkg.sv
// Shared types, token codes and keyword tables for the source text tokenizer.
// No dependencies; every other file in hdl imports this package.
package stt_pkg;

   localparam int unsigned POSITION_BITS_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned KW_COUNT = 13;

   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic ERR_ESCAPE = 1'b0;
   localparam logic ERR_UNTERM = 1'b1;

   localparam logic [5:0] TOK_IDENT   = 6'd0;
   localparam logic [5:0] TOK_NUMBER  = 6'd1;
   localparam logic [5:0] TOK_STRING  = 6'd2;
   localparam logic [5:0] TOK_KW0     = 6'd3;
   localparam logic [5:0] TOK_LPAREN  = 6'd16;
   localparam logic [5:0] TOK_RPAREN  = 6'd17;
   localparam logic [5:0] TOK_LBRACE  = 6'd18;
   localparam logic [5:0] TOK_RBRACE  = 6'd19;
   localparam logic [5:0] TOK_SEMI    = 6'd20;
   localparam logic [5:0] TOK_COMMA   = 6'd21;
   localparam logic [5:0] TOK_DOT     = 6'd22;
   localparam logic [5:0] TOK_EQ      = 6'd23;
   localparam logic [5:0] TOK_EQEQ    = 6'd24;
   localparam logic [5:0] TOK_NE      = 6'd25;
   localparam logic [5:0] TOK_LESS    = 6'd26;
   localparam logic [5:0] TOK_GREATER = 6'd27;
   localparam logic [5:0] TOK_AMP     = 6'd28;
   localparam logic [5:0] TOK_PLUS    = 6'd29;
   localparam logic [5:0] TOK_MINUS   = 6'd30;
   localparam logic [5:0] TOK_STAR    = 6'd31;
   localparam logic [5:0] TOK_SLASH   = 6'd32;
   localparam logic [5:0] TOK_UNKNOWN = 6'd33;
   localparam logic [5:0] TOK_EOF     = 6'd34;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_T     = 8'h74;

   // keyword text is right-justified: first character sits in the top used byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "function", "if", "else", "for", "while", "return", "init",
      "int", "string", "bool", "void", "true", "false"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd8, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4, 4'd3, 4'd6, 4'd4, 4'd4, 4'd4, 4'd5
   };

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_SLASH,
      MODE_EQ,
      MODE_BANG,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_ERR_ESC,
      MODE_ERR_UNTERM
   } stt_mode_type;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       end_of_source;
   } stt_req_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [5:0]  token_type;
      logic [7:0]  value_byte;
      logic [15:0] value_length;
      logic [15:0] line;
      logic [15:0] column;
      logic        error_code;
      logic        last_of_item;
   } stt_rsp_type;

   // all results of one item; rec_b is used only when pair is set
   typedef struct packed {
      logic        pair;
      stt_rsp_type rec_a;
      stt_rsp_type rec_b;
   } stt_entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } stt_qstat_type;

   function automatic stt_rsp_type make_rec(input logic [1:0] kind, input logic [5:0] ttype,
                                            input logic [7:0] vb, input logic [15:0] vlen,
                                            input logic [15:0] ln, input logic [15:0] col,
                                            input logic err);
      stt_rsp_type r;
      r.record_kind  = kind;
      r.token_type   = ttype;
      r.value_byte   = vb;
      r.value_length = vlen;
      r.line         = ln;
      r.column       = col;
      r.error_code   = err;
      r.last_of_item = 1'b0;
      return r;
   endfunction

   function automatic logic [5:0] punct_type(input logic [7:0] c);
      logic [5:0] t;
      case (c)
         8'h28:   t = TOK_LPAREN;
         8'h29:   t = TOK_RPAREN;
         8'h7B:   t = TOK_LBRACE;
         8'h7D:   t = TOK_RBRACE;
         8'h3B:   t = TOK_SEMI;
         8'h2C:   t = TOK_COMMA;
         8'h2E:   t = TOK_DOT;
         8'h3C:   t = TOK_LESS;
         8'h3E:   t = TOK_GREATER;
         8'h26:   t = TOK_AMP;
         8'h2B:   t = TOK_PLUS;
         8'h2D:   t = TOK_MINUS;
         8'h2A:   t = TOK_STAR;
         default: t = TOK_UNKNOWN;
      endcase
      return t;
   endfunction

   // drop keywords that cannot match once character c lands at position count
   function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] cand,
                                                     input logic [15:0] count,
                                                     input logic [7:0] c);
      logic [KW_COUNT-1:0] keep;
      logic [5:0]          sh;
      keep = cand;
      sh = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (count >= 16'(KW_LEN[k])) begin
            keep[k] = 1'b0;
         end else begin
            sh = 6'({KW_LEN[k] - 4'd1 - count[3:0], 3'b000});
            if (KW_TEXT[k][sh +: 8] != c) keep[k] = 1'b0;
         end
      end
      return keep;
   endfunction

   function automatic logic [5:0] kw_type(input logic [KW_COUNT-1:0] cand,
                                          input logic [15:0] count);
      logic [5:0] t;
      t = TOK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (cand[k] && count == 16'(KW_LEN[k])) t = 6'(TOK_KW0 + 6'(k));
      end
      return t;
   endfunction

endpackage

### hdl/stt_queue.sv
// Short result queue between the lexer front end and the output stage.
// One entry holds all results of one source item. Depends on stt_pkg.
module stt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  stt_pkg::stt_entry_type push_entry,
   input  logic                   pop,
   output stt_pkg::stt_entry_type head_entry,
   output stt_pkg::stt_qstat_type qstat
);
   import stt_pkg::*;

   localparam int unsigned DEPTH = QUEUE_DEPTH;
   localparam int unsigned PTR_BITS = $clog2(DEPTH);
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   stt_entry_type       entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

   assign head_entry      = entries_ff[rd_ptr_ff];
   assign qstat.not_empty = (fill_ff != '0);
   assign qstat.full      = (fill_ff == CNT_BITS'(DEPTH));

endmodule

### hdl/stt_front.sv
// Lexer front end: accepts source bytes, tracks position and token state,
// and builds the one or two result records of each item. Depends on stt_pkg.
module stt_front #(
   parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  stt_pkg::stt_req_type   req_payload,
   output logic                   req_stall,
   output logic                   push,
   output stt_pkg::stt_entry_type push_entry,
   input  stt_pkg::stt_qstat_type qstat
);
   import stt_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   stt_mode_type             mode_ff, mode_in;
   logic [POSITION_BITS-1:0] line_ff, line_in, col_ff, col_in;
   logic [POSITION_BITS-1:0] tline_ff, tline_in, tcol_ff, tcol_in;
   logic [POSITION_BITS-1:0] step_line, step_col;
   logic [15:0]              count_ff, count_in, count_inc;
   logic [KW_COUNT-1:0]      cand_ff, cand_in;

   logic        accept;
   logic [7:0]  c;
   logic        eos;
   logic        is_blank, is_alpha, is_digit, is_ident_ch, is_punct;
   logic        esc_ok;
   logic [7:0]  esc_val;
   logic [5:0]  ptype;
   logic        cont, flush_mode;
   stt_mode_type idle_mode;
   logic [15:0] line16, col16, tline16, tcol16;

   stt_rsp_type flush_rec, lead_rec, rec_a, rec_b;
   logic        has_flush, has_lead;

   assign accept    = req_valid && !req_stall;
   assign req_stall = qstat.full;
   assign c         = req_payload.byte_req;
   assign eos       = req_payload.end_of_source;

   assign line16  = 16'(line_ff);
   assign col16   = 16'(col_ff);
   assign tline16 = 16'(tline_ff);
   assign tcol16  = 16'(tcol_ff);

   // character classes and what the current mode does with this byte
   always_comb begin : classify
      is_blank    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
      is_alpha    = (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
      is_digit    = c inside {[8'h30:8'h39]};
      is_ident_ch = is_alpha || is_digit || (c == CH_UNDER);
      ptype       = punct_type(c);
      is_punct    = (ptype != TOK_UNKNOWN);
      esc_ok      = (c == CH_N) || (c == CH_T) || (c == CH_BSL) || (c == CH_QUOTE);
      esc_val     = (c == CH_N) ? CH_LF : ((c == CH_T) ? CH_TAB : c);
      flush_mode  = mode_ff inside {MODE_SLASH, MODE_EQ, MODE_BANG, MODE_IDENT, MODE_NUMBER};

      case (mode_ff)
         MODE_COMMENT, MODE_STRING, MODE_ESCAPE: cont = 1'b1;
         MODE_SLASH:                             cont = (c == CH_SLASH);
         MODE_EQ, MODE_BANG:                     cont = (c == CH_EQUAL);
         MODE_IDENT:                             cont = is_ident_ch;
         MODE_NUMBER:                            cont = is_digit;
         default:                                cont = 1'b0;
      endcase

      if (c == CH_SLASH)                     idle_mode = MODE_SLASH;
      else if (c == CH_EQUAL)                idle_mode = MODE_EQ;
      else if (c == CH_BANG)                 idle_mode = MODE_BANG;
      else if (c == CH_QUOTE)                idle_mode = MODE_STRING;
      else if (is_alpha || c == CH_UNDER)    idle_mode = MODE_IDENT;
      else if (is_digit)                     idle_mode = MODE_NUMBER;
      else                                   idle_mode = MODE_IDLE;
   end

   always_comb begin : next_mode
      mode_in = mode_ff;
      case (mode_ff)
         MODE_ERR_ESC, MODE_ERR_UNTERM: mode_in = mode_ff;
         default: begin
            if (eos) begin
               if (mode_ff == MODE_STRING)      mode_in = MODE_ERR_UNTERM;
               else if (mode_ff == MODE_ESCAPE) mode_in = MODE_ERR_ESC;
               else                             mode_in = MODE_IDLE;
            end else if (cont) begin
               case (mode_ff)
                  MODE_COMMENT: mode_in = (c == CH_LF) ? MODE_IDLE : MODE_COMMENT;
                  MODE_SLASH:   mode_in = MODE_COMMENT;
                  MODE_IDENT:   mode_in = MODE_IDENT;
                  MODE_NUMBER:  mode_in = MODE_NUMBER;
                  MODE_STRING: begin
                     if (c == CH_QUOTE)    mode_in = MODE_IDLE;
                     else if (c == CH_BSL) mode_in = MODE_ESCAPE;
                     else                  mode_in = MODE_STRING;
                  end
                  MODE_ESCAPE:  mode_in = esc_ok ? MODE_STRING : MODE_ERR_ESC;
                  default:      mode_in = MODE_IDLE;
               endcase
            end else begin
               mode_in = idle_mode;
            end
         end
      endcase
   end

   always_comb begin : datapath
      count_inc = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
      if (c == CH_LF) begin
         step_line = (line_ff == '1) ? line_ff : line_ff + 1'b1;
         step_col  = POS_ONE;
      end else begin
         step_line = line_ff;
         step_col  = (col_ff == '1) ? col_ff : col_ff + 1'b1;
      end

      case (mode_ff)
         MODE_SLASH:  flush_rec = make_rec(KIND_TOKEN, TOK_SLASH, 8'd0, 16'd0,
                                           tline16, tcol16, 1'b0);
         MODE_EQ:     flush_rec = make_rec(KIND_TOKEN, TOK_EQ, 8'd0, 16'd0,
                                           tline16, tcol16, 1'b0);
         MODE_BANG:   flush_rec = make_rec(KIND_TOKEN, TOK_UNKNOWN, CH_BANG, 16'd0,
                                           tline16, tcol16, 1'b0);
         MODE_NUMBER: flush_rec = make_rec(KIND_TOKEN, TOK_NUMBER, 8'd0, count_ff,
                                           tline16, tcol16, 1'b0);
         MODE_IDENT:  flush_rec = make_rec(KIND_TOKEN, kw_type(cand_ff, count_ff), 8'd0,
                                           count_ff, tline16, tcol16, 1'b0);
         default:     flush_rec = '0;
      endcase

      line_in   = line_ff;
      col_in    = col_ff;
      tline_in  = tline_ff;
      tcol_in   = tcol_ff;
      count_in  = count_ff;
      cand_in   = cand_ff;
      has_flush = 1'b0;
      has_lead  = 1'b0;
      lead_rec  = '0;

      if (mode_ff == MODE_ERR_ESC || mode_ff == MODE_ERR_UNTERM) begin
         // sticky: repeat the error record, hold everything
         has_lead = 1'b1;
         lead_rec = make_rec(KIND_ERROR, TOK_IDENT, 8'd0, 16'd0, tline16, tcol16,
                             (mode_ff == MODE_ERR_UNTERM) ? ERR_UNTERM : ERR_ESCAPE);
      end else if (eos) begin
         has_lead = 1'b1;
         case (mode_ff)
            MODE_STRING: lead_rec = make_rec(KIND_ERROR, TOK_IDENT, 8'd0, 16'd0,
                                             tline16, tcol16, ERR_UNTERM);
            MODE_ESCAPE: begin
               tline_in = line_ff;
               tcol_in  = col_ff;
               lead_rec = make_rec(KIND_ERROR, TOK_IDENT, 8'd0, 16'd0,
                                   line16, col16, ERR_ESCAPE);
            end
            default: begin
               has_flush = flush_mode;
               lead_rec  = make_rec(KIND_TOKEN, TOK_EOF, 8'd0, 16'd0, line16, col16, 1'b0);
               line_in   = POS_ONE;
               col_in    = POS_ONE;
               tline_in  = POS_ONE;
               tcol_in   = POS_ONE;
               count_in  = '0;
               cand_in   = '1;
            end
         endcase
      end else begin
         // an escape error freezes the position at the offending byte
         if (!(mode_ff == MODE_ESCAPE && !esc_ok)) begin
            line_in = step_line;
            col_in  = step_col;
         end
         if (cont) begin
            case (mode_ff)
               MODE_EQ: begin
                  has_lead = 1'b1;
                  lead_rec = make_rec(KIND_TOKEN, TOK_EQEQ, 8'd0, 16'd0, tline16, tcol16, 1'b0);
               end
               MODE_BANG: begin
                  has_lead = 1'b1;
                  lead_rec = make_rec(KIND_TOKEN, TOK_NE, 8'd0, 16'd0, tline16, tcol16, 1'b0);
               end
               MODE_IDENT: begin
                  has_lead = 1'b1;
                  cand_in  = kw_filter(cand_ff, count_ff, c);
                  count_in = count_inc;
                  lead_rec = make_rec(KIND_VALUE, TOK_IDENT, c, count_inc,
                                      tline16, tcol16, 1'b0);
               end
               MODE_NUMBER: begin
                  has_lead = 1'b1;
                  count_in = count_inc;
                  lead_rec = make_rec(KIND_VALUE, TOK_NUMBER, c, count_inc,
                                      tline16, tcol16, 1'b0);
               end
               MODE_STRING: begin
                  if (c == CH_QUOTE) begin
                     has_lead = 1'b1;
                     lead_rec = make_rec(KIND_TOKEN, TOK_STRING, 8'd0, count_ff,
                                         tline16, tcol16, 1'b0);
                  end else if (c != CH_BSL) begin
                     has_lead = 1'b1;
                     count_in = count_inc;
                     lead_rec = make_rec(KIND_VALUE, TOK_STRING, c, count_inc,
                                         tline16, tcol16, 1'b0);
                  end
               end
               MODE_ESCAPE: begin
                  has_lead = 1'b1;
                  if (esc_ok) begin
                     count_in = count_inc;
                     lead_rec = make_rec(KIND_VALUE, TOK_STRING, esc_val, count_inc,
                                         tline16, tcol16, 1'b0);
                  end else begin
                     tline_in = line_ff;
                     tcol_in  = col_ff;
                     lead_rec = make_rec(KIND_ERROR, TOK_IDENT, 8'd0, 16'd0,
                                         line16, col16, ERR_ESCAPE);
                  end
               end
               default: ;
            endcase
         end else begin
            // close any pending token, then lex this byte from idle
            has_flush = flush_mode;
            if (!is_blank) begin
               tline_in = line_ff;
               tcol_in  = col_ff;
               count_in = '0;
               cand_in  = '1;
               if (is_punct) begin
                  has_lead = 1'b1;
                  lead_rec = make_rec(KIND_TOKEN, ptype, 8'd0, 16'd0, line16, col16, 1'b0);
               end else if (is_alpha || c == CH_UNDER) begin
                  has_lead = 1'b1;
                  cand_in  = kw_filter('1, 16'd0, c);
                  count_in = 16'd1;
                  lead_rec = make_rec(KIND_VALUE, TOK_IDENT, c, 16'd1, line16, col16, 1'b0);
               end else if (is_digit) begin
                  has_lead = 1'b1;
                  count_in = 16'd1;
                  lead_rec = make_rec(KIND_VALUE, TOK_NUMBER, c, 16'd1, line16, col16, 1'b0);
               end else if (idle_mode == MODE_IDLE) begin
                  has_lead = 1'b1;
                  lead_rec = make_rec(KIND_TOKEN, TOK_UNKNOWN, c, 16'd0, line16, col16, 1'b0);
               end
            end
         end
      end

      rec_a = has_flush ? flush_rec : lead_rec;
      rec_b = lead_rec;
      if (has_flush && has_lead) rec_b.last_of_item = 1'b1;
      else                       rec_a.last_of_item = 1'b1;

      push_entry.pair  = has_flush && has_lead;
      push_entry.rec_a = rec_a;
      push_entry.rec_b = rec_b;
      push             = accept && (has_flush || has_lead);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         tline_ff <= POS_ONE;
         tcol_ff  <= POS_ONE;
         count_ff <= '0;
         cand_ff  <= '1;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         count_ff <= count_in;
         cand_ff  <= cand_in;
      end
   end

endmodule

### hdl/stt_back.sv
// Output stage: pulls queue entries and presents their records one per transfer.
// Depends on stt_pkg.
module stt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  stt_pkg::stt_entry_type head_entry,
   input  stt_pkg::stt_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   output stt_pkg::stt_rsp_type   rsp_payload,
   input  logic                   rsp_stall
);
   import stt_pkg::*;

   stt_entry_type hold_ff, hold_in;
   logic          hold_valid_ff, hold_valid_in;
   logic          show_b_ff, show_b_in;
   logic          out_fire, done;

   always_comb begin
      out_fire      = hold_valid_ff && !rsp_stall;
      done          = !hold_valid_ff || (out_fire && (show_b_ff || !hold_ff.pair));
      pop           = done && qstat.not_empty;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      show_b_in     = show_b_ff;
      if (done) begin
         // refill from the queue as the last record of the entry leaves
         hold_in       = head_entry;
         hold_valid_in = qstat.not_empty;
         show_b_in     = 1'b0;
      end else if (out_fire) begin
         show_b_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         show_b_ff     <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         show_b_ff     <= show_b_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign rsp_valid   = hold_valid_ff;
   assign rsp_payload = show_b_ff ? hold_ff.rec_b : hold_ff.rec_a;

endmodule

### hdl/source_text_tokenizer_unit.sv
// Source text tokenizer, top level: lexer front end, result queue, output stage.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
//   channel  direction  payload        handshake
//   req      in         stt_req_type   req_valid / req_stall
//   rsp      out        stt_rsp_type   rsp_valid / rsp_stall
//
// One source byte is taken per cycle while req_stall is low; its one or two records
// are built in that cycle and queued. The output stage sends one record per cycle
// while rsp_stall is low, so an item that yields two records (a closed token plus
// the next one) holds the output for both. The 4-entry queue absorbs those bursts;
// req_stall rises only when it is full. A record passes a queue entry, then the output hold register.
// Synchronous reset clears mode, counters and the queue; no sweep.
module source_text_tokenizer_unit #(
   parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  stt_pkg::stt_req_type req_payload,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output stt_pkg::stt_rsp_type rsp_payload,
   input  logic                 rsp_stall
);
   import stt_pkg::*;

   logic          push, pop;
   stt_entry_type push_entry, head_entry;
   stt_qstat_type qstat;

   stt_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .push        (push),
      .push_entry  (push_entry),
      .qstat       (qstat)
   );

   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   stt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_entry  (head_entry),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

`ifndef SYNTHESIS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("result queue written while full");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.record_kind == KIND_ERROR) |-> rsp_payload.last_of_item)
      else $error("error record not last of its item");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.record_kind == KIND_TOKEN &&
       rsp_payload.token_type == TOK_EOF) |-> rsp_payload.last_of_item)
      else $error("end-of-file token not last of its item");

   a_value_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.record_kind == KIND_VALUE) |->
      (rsp_payload.value_length != 16'd0))
      else $error("value byte with zero length");
`endif

endmodule
